FILE: design/palu_pkg.sv
// palu_pkg: shared types and constants for the positional array list unit.
// Depends on nothing; every other file in design/ uses it.
`default_nettype none

package palu_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 8;
  // cells per OR-reduction group in the read path
  localparam int unsigned GRP     = 16;

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_SET    = 2'd3
  } op_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic             en;
    op_t              op;
    logic [POS_W-1:0] pos_m1;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: design/palu_req_if.sv
// palu_req_if: request channel (func, position, value) with valid/ready.
// Depends on palu_pkg for field widths.
`default_nettype none

interface palu_req_if;
  logic                                valid;
  logic                                ready;
  logic [palu_pkg::FUNC_W-1:0]         func;
  logic [palu_pkg::POS_W-1:0]          position;
  logic signed [palu_pkg::DATA_W-1:0]  value;

  modport source (output valid, func, position, value, input ready);
  modport sink   (input valid, func, position, value, output ready);
endinterface

`default_nettype wire

FILE: design/palu_rsp_if.sv
// palu_rsp_if: result channel (status, read value, count, flags) with valid/ready.
// Depends on palu_pkg for field widths.
`default_nettype none

interface palu_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                status;
  logic signed [palu_pkg::DATA_W-1:0]  read_value;
  logic [palu_pkg::COUNT_W-1:0]        count;
  logic                                is_empty_flag;
  logic                                is_full_flag;

  modport source (output valid, status, read_value, count, is_empty_flag, is_full_flag,
                  input ready);
  modport sink   (input valid, status, read_value, count, is_empty_flag, is_full_flag,
                  output ready);
endinterface

`default_nettype wire

FILE: design/positional_array_list_unit.sv
// positional_array_list_unit: ordered list of signed words with insert, remove,
// get and set at a 1-based position. Depends on palu_pkg, palu_req_if, palu_rsp_if, palu_chain.
//
//  channel   dir  payload                                          handshake
//  in_req    in   func[1:0] position[7:0] value[31:0]              valid/ready
//  out_rsp   out  status read_value[31:0] count[7:0] empty full    valid/ready
//
// Execute stage: every cell of the chain moves at once. Read-finish stage: the OR-tree
// picks out the word a get reads. The result then moves into the output register and
// in_req.ready returns with it, so a new request waits until the last leaves both stages.
// rst_n (synchronous) clears the count and all valid bits; list words are not reset.
// A stalled out_rsp holds its result register; one more transaction can be taken and
// held in the read-finish stage, after which in_req.ready stays low until the output drains.
`default_nettype none

module positional_array_list_unit #(
  parameter int unsigned CAPACITY = 128
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  palu_req_if.sink   in_req,
  palu_rsp_if.source out_rsp
);
  import palu_pkg::*;

  localparam int unsigned NGROUP = (CAPACITY + GRP - 1) / GRP;
  localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAPACITY);

  // list length
  logic [COUNT_W-1:0] count_r, count_nxt;

  // execute stage: the registered request
  logic              a_v_r;
  logic              a_ok_r;
  op_t               a_op_r;
  logic [POS_W-1:0]  a_pos_m1_r;
  logic [DATA_W-1:0] a_val_r;

  // read-finish stage
  logic               b_v_r;
  logic               b_status_r;
  logic               b_get_r;
  logic [COUNT_W-1:0] b_count_r;

  // output register
  logic               o_v_r;
  logic               o_status_r;
  logic [DATA_W-1:0]  o_rd_r;
  logic [COUNT_W-1:0] o_count_r;

  logic              in_fire;
  logic              req_ok;
  op_t               req_op;
  logic [COUNT_W:0]  count_p1;
  logic              pos_ok;
  logic              b_move;
  logic [DATA_W-1:0] grp [NGROUP];
  logic [DATA_W-1:0] rd_or;
  cell_ctl_t         ctl;

  assign in_req.ready = !a_v_r && !b_v_r;
  assign in_fire      = in_req.valid && in_req.ready;
  assign req_op       = op_t'(in_req.func);

  // bounds check against the count seen at accept (no other transaction in flight)
  assign count_p1 = {1'b0, count_r} + (COUNT_W+1)'(1);
  assign pos_ok   = (in_req.position != '0) && (in_req.position <= count_r);

  always_comb begin
    case (req_op)
      OP_INSERT: req_ok = (in_req.position != '0)
                       && ({1'b0, in_req.position} <= count_p1)
                       && (count_r != CAP_C);
      default:   req_ok = pos_ok;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_ok_r     <= req_ok;
      a_op_r     <= req_op;
      a_pos_m1_r <= in_req.position - POS_W'(1);
      a_val_r    <= in_req.value;
    end
  end

  // broadcast to the cells; only an in-range request touches the list
  always_comb begin
    ctl.en     = a_v_r;
    ctl.op     = a_ok_r ? a_op_r : OP_GET;
    ctl.pos_m1 = a_pos_m1_r;
  end

  palu_chain #(.CAPACITY(CAPACITY)) u_chain (
    .clk   (clk),
    .ctl   (ctl),
    .val   (a_val_r),
    .grp_o (grp)
  );

  always_comb begin
    count_nxt = count_r;
    if (a_v_r && a_ok_r) begin
      case (a_op_r)
        OP_INSERT: count_nxt = count_r + COUNT_W'(1);
        OP_REMOVE: count_nxt = count_r - COUNT_W'(1);
        default:   count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // read-finish stage; grp holds steady while it waits since in_req stays blocked
  assign b_move = b_v_r && (!o_v_r || out_rsp.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (a_v_r) begin
      b_v_r <= 1'b1;
    end else if (b_move) begin
      b_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_v_r) begin
      b_status_r <= !a_ok_r;
      b_get_r    <= a_ok_r && (a_op_r == OP_GET);
      b_count_r  <= count_nxt;
    end
  end

  always_comb begin
    rd_or = '0;
    for (int g = 0; g < NGROUP; g++) begin
      rd_or = rd_or | grp[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (b_move) begin
      o_v_r <= 1'b1;
    end else if (out_rsp.ready) begin
      o_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      o_status_r <= b_status_r;
      o_rd_r     <= b_get_r ? rd_or : '0;
      o_count_r  <= b_count_r;
    end
  end

  assign out_rsp.valid         = o_v_r;
  assign out_rsp.status        = o_status_r;
  assign out_rsp.read_value    = o_rd_r;
  assign out_rsp.count         = o_count_r;
  assign out_rsp.is_empty_flag = (o_count_r == '0);
  assign out_rsp.is_full_flag  = (o_count_r == CAP_C);

  // the execute stage never holds its request
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r |=> !a_v_r)
    else $error("execute stage held for more than one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("list count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && a_ok_r && a_op_r == OP_INSERT) |=> count_r == $past(count_r) + COUNT_W'(1))
    else $error("insert did not grow the list by one");

  a_error_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && !a_ok_r) |=> $stable(count_r))
    else $error("rejected request changed the count");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r |-> !b_v_r || b_move)
    else $error("execute started while read stage still busy");

endmodule

`default_nettype wire

FILE: design/palu_cell.sv
// palu_cell: one list slot; loads the broadcast value or a neighbor's word.
// Depends on palu_pkg.
`default_nettype none

module palu_cell #(
  parameter logic [7:0] IDX = 8'd0
) (
  input  wire logic                          clk,
  input  wire palu_pkg::cell_ctl_t           ctl,
  input  wire logic [palu_pkg::DATA_W-1:0]   val,
  input  wire logic [palu_pkg::DATA_W-1:0]   left_d,
  input  wire logic [palu_pkg::DATA_W-1:0]   right_d,
  output logic      [palu_pkg::DATA_W-1:0]   data_o,
  output logic      [palu_pkg::DATA_W-1:0]   hit_o
);
  import palu_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              at_pos;

  assign at_pos = (IDX == ctl.pos_m1);

  always_comb begin
    data_nxt = data_r;
    if (ctl.en) begin
      case (ctl.op)
        OP_INSERT: begin
          if (at_pos)                  data_nxt = val;
          else if (IDX > ctl.pos_m1)   data_nxt = left_d;
        end
        OP_REMOVE: begin
          if (IDX >= ctl.pos_m1)       data_nxt = right_d;
        end
        OP_SET: begin
          if (at_pos)                  data_nxt = val;
        end
        default: data_nxt = data_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign hit_o  = at_pos ? data_r : '0;

endmodule

`default_nettype wire

FILE: design/palu_chain.sv
// palu_chain: row of palu_cell slots plus the registered first level of the
// read OR-tree (one register per group of GRP cells). Depends on palu_pkg, palu_cell.
`default_nettype none

module palu_chain #(
  parameter int unsigned CAPACITY = 128,
  localparam int unsigned NGROUP  = (CAPACITY + palu_pkg::GRP - 1) / palu_pkg::GRP
) (
  input  wire logic                         clk,
  input  wire palu_pkg::cell_ctl_t          ctl,
  input  wire logic [palu_pkg::DATA_W-1:0]  val,
  output logic      [palu_pkg::DATA_W-1:0]  grp_o [NGROUP]
);
  import palu_pkg::*;

  localparam int unsigned NPAD = NGROUP * GRP;

  logic [DATA_W-1:0] data [CAPACITY];
  logic [DATA_W-1:0] hit  [NPAD];
  logic [DATA_W-1:0] grp_r   [NGROUP];
  logic [DATA_W-1:0] grp_nxt [NGROUP];

  for (genvar k = 0; k < NPAD; k++) begin : g_cell
    if (k < CAPACITY) begin : g_real
      palu_cell #(.IDX(8'(k))) u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .val     (val),
        .left_d  ((k == 0) ? val : data[(k == 0) ? 0 : k-1]),
        .right_d ((k == CAPACITY-1) ? '0 : data[(k == CAPACITY-1) ? k : k+1]),
        .data_o  (data[k]),
        .hit_o   (hit[k])
      );
    end else begin : g_pad
      assign hit[k] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        grp_nxt[g] = grp_nxt[g] | hit[g*GRP + j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      grp_r <= grp_nxt;
    end
  end

  assign grp_o = grp_r;

endmodule

`default_nettype wire
